>>> rtl/ppp_async_hdlc_deframer_assert.svh
// Assertion macros used by the deframer top level, ppp_async_hdlc_deframer.
// Needs nothing else; the including module supplies the clock and reset names.
`ifndef PPP_ASYNC_HDLC_DEFRAMER_ASSERT_SVH
`define PPP_ASYNC_HDLC_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PHDLC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PHDLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

>>> rtl/phdlc_pkg.sv
// Constants, result type and FCS-16 byte update for the PPP async HDLC deframer.
// Used by phdlc_core and ppp_async_hdlc_deframer; depends on nothing.
`timescale 1ns / 1ps

package phdlc_pkg;

   localparam logic [7:0]  FlagByte = 8'h7E;
   localparam logic [7:0]  EscByte  = 8'h7D;
   localparam logic [7:0]  EscXor   = 8'h20;
   localparam logic [7:0]  AddrByte = 8'hFF;
   localparam logic [7:0]  CtrlByte = 8'h03;
   localparam logic [15:0] FcsInit  = 16'hFFFF;
   localparam logic [15:0] FcsGood  = 16'hF0B8;
   localparam logic [15:0] FcsPoly  = 16'h8408;
   localparam logic [2:0]  MinFrame = 3'd6;

   localparam logic       KindPayload = 1'b0;
   localparam logic       KindEnd     = 1'b1;

   localparam logic [1:0] StatusGood  = 2'd0;
   localparam logic [1:0] StatusBadFcs = 2'd1;
   localparam logic [1:0] StatusShort = 2'd2;

   typedef struct packed {
      logic        valid;
      logic        kind;
      logic [7:0]  payload_byte;
      logic [15:0] protocol;
      logic [1:0]  status;
      logic        frame_last;
   } result_type;

   function automatic logic [15:0] fcs16_update(input logic [15:0] fcs, input logic [7:0] b);
      logic [15:0] v;
      v = fcs ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         v = v[0] ? ((v >> 1) ^ FcsPoly) : (v >> 1);
      end
      return v;
   endfunction

endpackage

>>> rtl/ppp_async_hdlc_deframer.sv
// PPP asynchronous HDLC deframer with FCS-16 check: input register, frame core, result register.
// A byte moves from the input register through the core into the result register, which drives the response port.
// Throughput: one byte per cycle while the result side accepts; the core steps once per byte.
// The input register holds a byte only while the result register is full and stalled.
// Reset is synchronous and active high; it empties both registers and clears frame state.
// Depends on phdlc_pkg, phdlc_core and ppp_async_hdlc_deframer_assert.svh.
`timescale 1ns / 1ps
`include "ppp_async_hdlc_deframer_assert.svh"

module ppp_async_hdlc_deframer
   import phdlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] payload_byte, [23:8] protocol, [25:24] status
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_ff;
   result_type  result;
   logic        step_en;
   logic        req_xfer;

   assign step_en    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_en;
   assign req_xfer   = req_tvalid && req_tready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !step_en);
   assign rsp_valid_in = step_en ? result.valid : (rsp_valid_ff && !rsp_tready);

   phdlc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
      end
      if (step_en && result.valid) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.status, rsp_ff.protocol, rsp_ff.payload_byte};
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.frame_last;

   `PHDLC_ASSERT_SAME(a_payload_clean, clock, reset,
      rsp_tvalid && rsp_tuser == KindPayload, !rsp_tlast && rsp_tdata[25:8] == 18'd0)
   `PHDLC_ASSERT_SAME(a_end_clean, clock, reset,
      rsp_tvalid && rsp_tuser == KindEnd, rsp_tlast && rsp_tdata[7:0] == 8'd0 &&
      rsp_tdata[25:24] != 2'd3)
   `PHDLC_ASSERT_SAME(a_stall_only_when_held, clock, reset,
      !req_tready, in_valid_ff && rsp_tvalid && !rsp_tready)
   `PHDLC_ASSERT_NEXT(a_held_byte_kept, clock, reset,
      in_valid_ff && !step_en, in_valid_ff && $stable(in_byte_ff))

endmodule

>>> rtl/phdlc_core.sv
// Frame state of the deframer: unstuffing, FCS-16, header decode, payload delay line.
// Depends on phdlc_pkg; produces at most one result for each stepped byte.
`timescale 1ns / 1ps

module phdlc_core
   import phdlc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] rx_byte,
   output result_type result
);

   localparam logic [2:0] PhaseFirst   = 3'd0;
   localparam logic [2:0] PhaseAddr    = 3'd1;
   localparam logic [2:0] PhaseProto1  = 3'd2;
   localparam logic [2:0] PhaseProto2  = 3'd3;
   localparam logic [2:0] PhaseHeld0   = 3'd4;
   localparam logic [2:0] PhaseHeld1   = 3'd5;
   localparam logic [2:0] PhaseHeld2   = 3'd6;

   logic        in_frame_ff, in_frame_in;
   logic        escape_ff, escape_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [2:0]  count_ff, count_in;
   logic [2:0]  phase_ff, phase_in;
   logic [15:0] proto_ff, proto_in;
   logic [7:0]  ub;

   always_comb begin
      in_frame_in = in_frame_ff;
      escape_in   = escape_ff;
      crc_in      = crc_ff;
      held0_in    = held0_ff;
      held1_in    = held1_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      proto_in    = proto_ff;
      result      = '0;
      ub          = escape_ff ? (rx_byte ^ EscXor) : rx_byte;

      if (rx_byte == FlagByte) begin
         if (!in_frame_ff || count_ff != 3'd0) begin
            if (in_frame_ff) begin
               result.valid      = 1'b1;
               result.kind       = KindEnd;
               result.protocol   = proto_ff;
               result.frame_last = 1'b1;
               if (count_ff < MinFrame) begin
                  result.status = StatusShort;
               end else if (crc_ff != FcsGood) begin
                  result.status = StatusBadFcs;
               end else begin
                  result.status = StatusGood;
               end
            end
            in_frame_in = 1'b1;
            crc_in      = FcsInit;
            held0_in    = 8'h00;
            held1_in    = 8'h00;
            count_in    = 3'd0;
            phase_in    = PhaseFirst;
            proto_in    = 16'h0000;
         end
         escape_in = 1'b0;
      end else if (in_frame_ff) begin
         if (rx_byte == EscByte) begin
            escape_in = 1'b1;
         end else begin
            escape_in = 1'b0;
            crc_in    = fcs16_update(crc_ff, ub);
            if (count_ff < MinFrame) begin
               count_in = count_ff + 3'd1;
            end
            case (phase_ff)
               PhaseFirst, PhaseProto1: begin
                  if (phase_ff == PhaseFirst && ub == AddrByte) begin
                     phase_in = PhaseAddr;
                  end else if (ub[0]) begin
                     proto_in = {8'h00, ub};
                     phase_in = PhaseHeld0;
                  end else begin
                     proto_in = {ub, 8'h00};
                     phase_in = PhaseProto2;
                  end
               end
               PhaseAddr: begin
                  if (ub == CtrlByte) begin
                     phase_in = PhaseProto1;
                  end else begin
                     proto_in = {8'h00, AddrByte};
                     held0_in = ub;
                     phase_in = PhaseHeld1;
                  end
               end
               PhaseProto2: begin
                  proto_in = {proto_ff[15:8], ub};
                  phase_in = PhaseHeld0;
               end
               PhaseHeld0: begin
                  held0_in = ub;
                  phase_in = PhaseHeld1;
               end
               PhaseHeld1: begin
                  held1_in = ub;
                  phase_in = PhaseHeld2;
               end
               default: begin
                  result.valid        = 1'b1;
                  result.kind         = KindPayload;
                  result.payload_byte = held0_ff;
                  held0_in            = held1_ff;
                  held1_in            = ub;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         crc_ff      <= FcsInit;
         held0_ff    <= 8'h00;
         held1_ff    <= 8'h00;
         count_ff    <= 3'd0;
         phase_ff    <= PhaseFirst;
         proto_ff    <= 16'h0000;
      end else if (step_en) begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         crc_ff      <= crc_in;
         held0_ff    <= held0_in;
         held1_ff    <= held1_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         proto_ff    <= proto_in;
      end
   end

endmodule
